// File: hw/rtl/izh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// izh_pkg
// Shared types, codes and helpers of the Izhikevich neuron RK4 step block.
// ----------------------------------------------------------------------------
package izh_pkg;

  // configuration port geometry
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 24;

  // field widths fixed by the interface
  localparam int IDX_W  = 10;
  localparam int CUR_W  = 24;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 16;
  localparam int COEF_W = 17;
  localparam int KS_W   = 35;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_COEF_A      = 3'd0,
    CFG_COEF_B      = 3'd1,
    CFG_RESET_POT   = 3'd2,
    CFG_REC_INC     = 3'd3,
    CFG_TIME_STEP   = 3'd4,
    CFG_THRESHOLD   = 3'd5,
    CFG_INIT_POT    = 3'd6,
    CFG_INIT_REC    = 3'd7
  } cfg_reg_t;

  // request kinds
  typedef enum logic {
    REQ_STEP = 1'b0,
    REQ_INIT = 1'b1
  } req_type_t;

  // item state carried down the pipeline
  typedef struct packed {
    logic                     init;
    logic                     oob;
    logic [IDX_W-1:0]         idx;
    logic signed [CUR_W-1:0]  cur;
    logic signed [VAL_W-1:0]  v;
    logic signed [VAL_W-1:0]  u;
    logic [CNT_W-1:0]         cnt;
    logic signed [KS_W-1:0]   ksv;
    logic signed [KS_W-1:0]   ksu;
  } item_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [71:0] x);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sd2147483647;
    lo = -72'sd2147483648;
    if (x > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[VAL_W-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/izh_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// izh_in_if
// Request channel: one step or init request for one neuron.
// ----------------------------------------------------------------------------
interface izh_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [9:0]  neuron_index;
  logic signed [23:0] drive_current;

  modport source (output valid, req_type, neuron_index, drive_current, input ready);
  modport sink (input valid, req_type, neuron_index, drive_current, output ready);
endinterface

// File: hw/rtl/izh_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// izh_out_if
// Result channel: updated neuron state, one per request.
// ----------------------------------------------------------------------------
interface izh_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  neuron_id;
  logic signed [31:0] potential;
  logic signed [31:0] recovery;
  logic        spiked;
  logic [15:0] spike_total;

  modport source (output valid, neuron_id, potential, recovery, spiked, spike_total,
                  input ready);
  modport sink (input valid, neuron_id, potential, recovery, spiked, spike_total,
                output ready);
endinterface

// File: hw/rtl/izh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// izh_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module izh_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/izh_rk_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// izh_rk_eval
// One RK4 slope evaluation: k = dt * f(v, u) for both state variables,
// six pipeline stages, with multipliers in the first, third and fifth stage.
// ----------------------------------------------------------------------------
module izh_rk_eval #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  izh_pkg::item_t            item_i,
  input  logic signed [31:0]        v_i,
  input  logic signed [31:0]        u_i,
  input  logic [16:0]               coef_a,
  input  logic [16:0]               coef_b,
  input  logic [16:0]               dt,
  output izh_pkg::item_t            item_o,
  output logic signed [31:0]        kv_o,
  output logic signed [31:0]        ku_o
);
  import izh_pkg::*;

  localparam int STAGES = 6;
  localparam logic signed [23:0] K04  = 24'(((4 << FRAC_BITS) + 50) / 100);
  localparam logic signed [39:0] C140 = 40'sd140 <<< FRAC_BITS;

  logic signed [63:0] psq_r;
  logic signed [49:0] pbv_r;
  logic signed [39:0] lin1_r, lin2_r, lin3_r;
  logic signed [31:0] u1_r;
  logic signed [31:0] sq_r, inner_r;
  logic signed [55:0] pk_r;
  logic signed [49:0] pa_r;
  logic signed [31:0] fv_r, fu_r;
  logic signed [49:0] pdv_r, pdu_r;
  logic signed [31:0] kv_r, ku_r;
  item_t              it_r [STAGES];

  // squares and products with v, linear terms
  always_ff @(posedge clk) begin
    if (en) begin
      psq_r  <= 64'(v_i) * 64'(v_i);
      pbv_r  <= 50'(v_i) * 50'($signed({1'b0, coef_b}));
      lin1_r <= 40'(v_i) + (40'(v_i) <<< 2) + C140 - 40'(u_i) + 40'(item_i.cur);
      u1_r   <= u_i;
    end
  end

  // rescale, clamp
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r    <= sat32(72'(psq_r >>> FRAC_BITS));
      inner_r <= sat32(72'(pbv_r >>> FRAC_BITS) - 72'(u1_r));
      lin2_r  <= lin1_r;
    end
  end

  // coefficient products
  always_ff @(posedge clk) begin
    if (en) begin
      pk_r   <= 56'(sq_r) * 56'(K04);
      pa_r   <= 50'(inner_r) * 50'($signed({1'b0, coef_a}));
      lin3_r <= lin2_r;
    end
  end

  // derivatives
  always_ff @(posedge clk) begin
    if (en) begin
      fv_r <= sat32(72'(pk_r >>> FRAC_BITS) + 72'(lin3_r));
      fu_r <= sat32(72'(pa_r >>> FRAC_BITS));
    end
  end

  // scale by time step
  always_ff @(posedge clk) begin
    if (en) begin
      pdv_r <= 50'(fv_r) * 50'($signed({1'b0, dt}));
      pdu_r <= 50'(fu_r) * 50'($signed({1'b0, dt}));
    end
  end

  // slopes
  always_ff @(posedge clk) begin
    if (en) begin
      kv_r <= sat32(72'(pdv_r >>> FRAC_BITS));
      ku_r <= sat32(72'(pdu_r >>> FRAC_BITS));
    end
  end

  // item delay line alongside the datapath
  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0] <= item_i;
      for (int i = 1; i < STAGES; i++) begin
        it_r[i] <= it_r[i-1];
      end
    end
  end

  assign item_o = it_r[STAGES-1];
  assign kv_o   = kv_r;
  assign ku_o   = ku_r;

endmodule

// File: hw/rtl/izhikevich_neuron_rk4_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// izhikevich_neuron_rk4_step
// Bank of Izhikevich neurons, one RK4 step or init per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries requests (req_type, neuron_index, drive_current); a request
//   is taken when valid and ready are high at a clock edge. out_res returns
//   one result per request in order. cfg_we/cfg_index/cfg_wdata write the
//   coefficient registers; write them only while no request is in flight.
// Throughput: one request per cycle while the pipeline advances and no item
//   for the same neuron is in flight. Neuron state lives in one RAM that is
//   read at request time and written back at the end of the 36-stage
//   pipeline, so a request for a neuron is held until its last item is written
//   back (longer while the receiver stalls); requests for other neurons flow.
// Reset: clears the pipeline, the result register and the coefficients to
//   their defaults. The state RAM is not cleared: a neuron must get an init
//   request before its first step.
// Stall: when out_res.ready is low the result register holds; the pipeline
//   keeps accepting until its last stage is also full.
// ----------------------------------------------------------------------------
module izhikevich_neuron_rk4_step #(
  parameter int NEURONS   = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  izh_in_if.sink                       in_req,
  izh_out_if.source                    out_res,
  input  logic                         cfg_we,
  input  logic [izh_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [izh_pkg::CFG_DW-1:0]   cfg_wdata
);
  import izh_pkg::*;

  localparam int AW    = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int RAM_W = 2 * VAL_W + CNT_W;
  localparam int L     = 36;

  // configuration registers
  logic [16:0]        coef_a_r, coef_b_r, time_step_r;
  logic signed [23:0] reset_pot_r, rec_inc_r, threshold_r, init_pot_r, init_rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r    <= 17'd1311;
      coef_b_r    <= 17'd13107;
      reset_pot_r <= -24'sd4259840;
      rec_inc_r   <= 24'sd524288;
      time_step_r <= 17'd6554;
      threshold_r <= 24'sd1966080;
      init_pot_r  <= -24'sd4259840;
      init_rec_r  <= -24'sd851968;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_COEF_A:    coef_a_r    <= cfg_wdata[16:0];
        CFG_COEF_B:    coef_b_r    <= cfg_wdata[16:0];
        CFG_RESET_POT: reset_pot_r <= cfg_wdata;
        CFG_REC_INC:   rec_inc_r   <= cfg_wdata;
        CFG_TIME_STEP: time_step_r <= cfg_wdata[16:0];
        CFG_THRESHOLD: threshold_r <= cfg_wdata;
        CFG_INIT_POT:  init_pot_r  <= cfg_wdata;
        CFG_INIT_REC:  init_rec_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic             adv;
  logic             hit;
  logic             accept;
  logic             tag_v_r   [L];
  logic [IDX_W-1:0] tag_idx_r [L];
  logic             out_valid_r;

  assign adv = !(tag_v_r[L-1] && out_valid_r && !out_res.ready);

  // same-neuron interlock against every item in flight
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < L; i++) begin
      if (tag_v_r[i] && (tag_idx_r[i] == in_req.neuron_index)) begin
        hit = 1'b1;
      end
    end
  end

  assign in_req.ready = adv && !hit;
  assign accept       = in_req.valid && in_req.ready;

  // occupancy and index of each stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L; i++) begin
        tag_v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      tag_v_r[0] <= accept;
      for (int i = 1; i < L; i++) begin
        tag_v_r[i] <= tag_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_idx_r[0] <= in_req.neuron_index;
      for (int i = 1; i < L; i++) begin
        tag_idx_r[i] <= tag_idx_r[i-1];
      end
    end
  end

  // state memory: {v, u, count}
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;

  izh_ram #(.WIDTH(RAM_W), .DEPTH(NEURONS)) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (AW'(in_req.neuron_index)),
    .rdata (ram_rdata)
  );

  // request capture while the read is under way
  logic                    s0_init_r, s0_oob_r;
  logic [IDX_W-1:0]        s0_idx_r;
  logic signed [CUR_W-1:0] s0_cur_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_init_r <= (in_req.req_type == REQ_INIT);
      s0_oob_r  <= (32'(in_req.neuron_index) >= NEURONS);
      s0_idx_r  <= in_req.neuron_index;
      s0_cur_r  <= in_req.drive_current;
    end
  end

  // join with stored state
  item_t s1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.init <= s0_init_r;
      s1_r.oob  <= s0_oob_r;
      s1_r.idx  <= s0_idx_r;
      s1_r.cur  <= s0_cur_r;
      s1_r.v    <= ram_rdata[RAM_W-1 -: VAL_W];
      s1_r.u    <= ram_rdata[CNT_W +: VAL_W];
      s1_r.cnt  <= ram_rdata[CNT_W-1:0];
      s1_r.ksv  <= '0;
      s1_r.ksu  <= '0;
    end
  end

  // four slope evaluations, the first three followed by an operand stage, the last by the final sum
  item_t              ev_in   [4];
  logic signed [31:0] ev_v    [4];
  logic signed [31:0] ev_u    [4];
  item_t              ev_out  [4];
  logic signed [31:0] ev_kv   [4];
  logic signed [31:0] ev_ku   [4];
  item_t              h_item_r [4];
  logic signed [31:0] hv_r    [3];
  logic signed [31:0] hu_r    [3];

  assign ev_in[0] = s1_r;
  assign ev_v[0]  = s1_r.v;
  assign ev_u[0]  = s1_r.u;

  for (genvar j = 0; j < 4; j++) begin : g_eval
    izh_rk_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
      .clk    (clk),
      .en     (adv),
      .item_i (ev_in[j]),
      .v_i    (ev_v[j]),
      .u_i    (ev_u[j]),
      .coef_a (coef_a_r),
      .coef_b (coef_b_r),
      .dt     (time_step_r),
      .item_o (ev_out[j]),
      .kv_o   (ev_kv[j]),
      .ku_o   (ev_ku[j])
    );

    if (j < 3) begin : g_mid
      item_t h_nxt;

      // weighted slope sum carried with the item
      always_comb begin
        h_nxt     = ev_out[j];
        h_nxt.ksv = ev_out[j].ksv + ((j == 0) ? KS_W'(ev_kv[j])
                                              : (KS_W'(ev_kv[j]) <<< 1));
        h_nxt.ksu = ev_out[j].ksu + ((j == 0) ? KS_W'(ev_ku[j])
                                              : (KS_W'(ev_ku[j]) <<< 1));
      end

      // next operand x + k/2 (x + k before the last evaluation)
      always_ff @(posedge clk) begin
        if (adv) begin
          h_item_r[j] <= h_nxt;
          if (j < 2) begin
            hv_r[j] <= sat32(72'(ev_out[j].v) + 72'(ev_kv[j] >>> 1));
            hu_r[j] <= sat32(72'(ev_out[j].u) + 72'(ev_ku[j] >>> 1));
          end else begin
            hv_r[j] <= sat32(72'(ev_out[j].v) + 72'(ev_kv[j]));
            hu_r[j] <= sat32(72'(ev_out[j].u) + 72'(ev_ku[j]));
          end
        end
      end
      assign ev_in[j+1] = h_item_r[j];
      assign ev_v[j+1]  = hv_r[j];
      assign ev_u[j+1]  = hu_r[j];
    end else begin : g_last
      item_t h_nxt;

      // final weighted sum k1 + 2k2 + 2k3 + k4
      always_comb begin
        h_nxt     = ev_out[j];
        h_nxt.ksv = ev_out[j].ksv + KS_W'(ev_kv[j]);
        h_nxt.ksu = ev_out[j].ksu + KS_W'(ev_ku[j]);
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          h_item_r[j] <= h_nxt;
        end
      end
    end
  end

  // divide the sums by six, truncating toward zero: |s|/2, then /3 in two
  // 17-bit halves by reciprocal multiplication
  localparam logic [17:0] RCP_HI = 18'd87382;
  localparam logic [18:0] RCP_LO = 19'd349526;

  item_t              c_item_r [5];
  logic               c1_neg_r [2];
  logic [16:0]        c1_h_r   [2];
  logic [16:0]        c1_l_r   [2];
  logic               c2_neg_r [2];
  logic [16:0]        c2_h_r   [2];
  logic [16:0]        c2_l_r   [2];
  logic [34:0]        c2_ph_r  [2];
  logic               c3_neg_r [2];
  logic [16:0]        c3_qh_r  [2];
  logic [18:0]        c3_x2_r  [2];
  logic               c4_neg_r [2];
  logic [16:0]        c4_qh_r  [2];
  logic [37:0]        c4_p2_r  [2];
  logic signed [31:0] c5_x_r   [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      c_item_r[0] <= h_item_r[3];
      for (int i = 1; i < 5; i++) begin
        c_item_r[i] <= c_item_r[i-1];
      end
    end
  end

  for (genvar n = 0; n < 2; n++) begin : g_div
    logic signed [KS_W-1:0] ks;
    logic [KS_W-1:0]        mag;
    logic [33:0]            half;
    logic [16:0]            qh;
    logic [1:0]             rh;
    logic [17:0]            q2;
    logic [KS_W-1:0]        q;
    logic signed [KS_W:0]   qs;
    logic signed [31:0]     x;

    assign ks   = (n == 0) ? h_item_r[3].ksv : h_item_r[3].ksu;
    assign mag  = ks[KS_W-1] ? KS_W'(-ks) : ks;
    assign half = mag[KS_W-1:1];
    assign qh   = c2_ph_r[n][34:18];
    assign rh   = 2'(c2_h_r[n] - 17'(qh * 2'd3));
    assign q2   = c4_p2_r[n][37:20];
    assign q    = {1'b0, c4_qh_r[n], 17'd0} + KS_W'(q2);
    assign qs   = c4_neg_r[n] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    assign x    = (n == 0) ? c_item_r[3].v : c_item_r[3].u;

    always_ff @(posedge clk) begin
      if (adv) begin
        c1_neg_r[n] <= ks[KS_W-1];
        c1_h_r[n]   <= half[33:17];
        c1_l_r[n]   <= half[16:0];

        c2_neg_r[n] <= c1_neg_r[n];
        c2_h_r[n]   <= c1_h_r[n];
        c2_l_r[n]   <= c1_l_r[n];
        c2_ph_r[n]  <= 35'(c1_h_r[n]) * 35'(RCP_HI);

        c3_neg_r[n] <= c2_neg_r[n];
        c3_qh_r[n]  <= qh;
        c3_x2_r[n]  <= {rh, c2_l_r[n]};

        c4_neg_r[n] <= c3_neg_r[n];
        c4_qh_r[n]  <= c3_qh_r[n];
        c4_p2_r[n]  <= 38'(c3_x2_r[n]) * 38'(RCP_LO);

        c5_x_r[n]   <= sat32(72'(x) + 72'(qs));
      end
    end
  end

  // spike test, init and out-of-range handling
  logic [IDX_W-1:0]   fin_idx_r;
  logic signed [31:0] fin_v_r, fin_u_r;
  logic               fin_spk_r, fin_oob_r;
  logic [CNT_W-1:0]   fin_cnt_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_idx_r <= c_item_r[4].idx;
      fin_oob_r <= c_item_r[4].oob;
      if (c_item_r[4].oob) begin
        fin_v_r   <= '0;
        fin_u_r   <= '0;
        fin_spk_r <= 1'b0;
        fin_cnt_r <= '0;
      end else if (c_item_r[4].init) begin
        fin_v_r   <= 32'(init_pot_r);
        fin_u_r   <= 32'(init_rec_r);
        fin_spk_r <= 1'b0;
        fin_cnt_r <= '0;
      end else if (c5_x_r[0] > 32'(threshold_r)) begin
        fin_v_r   <= 32'(reset_pot_r);
        fin_u_r   <= sat32(72'(c5_x_r[1]) + 72'(rec_inc_r));
        fin_spk_r <= 1'b1;
        fin_cnt_r <= (&c_item_r[4].cnt) ? c_item_r[4].cnt : c_item_r[4].cnt + 1'b1;
      end else begin
        fin_v_r   <= c5_x_r[0];
        fin_u_r   <= c5_x_r[1];
        fin_spk_r <= 1'b0;
        fin_cnt_r <= c_item_r[4].cnt;
      end
    end
  end

  // write back as the result leaves the pipeline
  assign ram_we    = adv && tag_v_r[L-1] && !fin_oob_r;
  assign ram_waddr = AW'(fin_idx_r);
  assign ram_wdata = {fin_v_r, fin_u_r, fin_cnt_r};

  // result register
  logic [IDX_W-1:0]   out_id_r;
  logic signed [31:0] out_v_r, out_u_r;
  logic               out_spk_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic               out_load;

  assign out_load = adv && tag_v_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_id_r  <= fin_idx_r;
      out_v_r   <= fin_v_r;
      out_u_r   <= fin_u_r;
      out_spk_r <= fin_spk_r;
      out_cnt_r <= fin_cnt_r;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.neuron_id   = out_id_r;
  assign out_res.potential   = out_v_r;
  assign out_res.recovery    = out_u_r;
  assign out_res.spiked      = out_spk_r;
  assign out_res.spike_total = out_cnt_r;

endmodule

// File: verif/izh_rk4_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// izh_rk4_checker
// Watches the request and result channels and the coefficient writes, keeps
// its own copy of the neuron bank, predicts each result with a bit-exact
// fixed-point RK4 step and compares the results in order.
// ----------------------------------------------------------------------------
module izh_rk4_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  izh_in_if                             in_req,
  izh_out_if                            out_res,
  input  logic                          cfg_we,
  input  logic [izh_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [izh_pkg::CFG_DW-1:0]    cfg_wdata,
  output int                            fail_count,
  output int                            pending_results
);
  import izh_pkg::*;

  typedef struct {
    logic [9:0]         id;
    logic signed [31:0] pot;
    logic signed [31:0] rec;
    logic               spk;
    logic [15:0]        total;
  } neuron_result_t;

  neuron_result_t     result_queue[$];
  logic [23:0]        coef_regs[8];
  logic signed [31:0] bank_v[1024];
  logic signed [31:0] bank_u[1024];
  logic [15:0]        bank_cnt[1024];

  assign pending_results = result_queue.size();

  function automatic longint reg_val(int i);
    if (i == CFG_COEF_A || i == CFG_COEF_B || i == CFG_TIME_STEP)
      return longint'({7'd0, coef_regs[i][16:0]});
    return longint'($signed(coef_regs[i]));
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // floor(x*y / 2^16); arithmetic shift floors
  function automatic longint qmul(longint x, longint y);
    return (x * y) >>> 16;
  endfunction

  function automatic longint rate_v(longint v, longint u, longint cur);
    longint k04, sq;
    k04 = ((64'sd4 <<< 16) + 50) / 100;
    sq = clamp32(qmul(v, v));
    return clamp32(qmul(k04, sq) + 5 * v + (64'sd140 <<< 16) - u + cur);
  endfunction

  function automatic longint rate_u(longint v, longint u);
    return clamp32(qmul(reg_val(CFG_COEF_A), clamp32(qmul(reg_val(CFG_COEF_B), v) - u)));
  endfunction

  function automatic longint rk4_sum(longint x, longint k1, longint k2, longint k3,
                                     longint k4);
    longint s, q;
    s = k1 + 2 * k2 + 2 * k3 + k4;
    q = (s >= 0) ? s / 6 : -((-s) / 6);
    return clamp32(x + q);
  endfunction

  // one request in, one expected result out; updates the local bank
  function automatic neuron_result_t advance_neuron(logic typ, logic [9:0] idx,
                                                    logic signed [23:0] cur_in);
    neuron_result_t r;
    longint v, u, dt, cur, hv, hu;
    longint kv[4], ku[4];
    int cnt;
    r.id = idx; r.spk = 0;
    dt = reg_val(CFG_TIME_STEP);
    cur = longint'(cur_in);
    if (typ == REQ_INIT) begin
      v = reg_val(CFG_INIT_POT);
      u = reg_val(CFG_INIT_REC);
      cnt = 0;
    end else begin
      v = bank_v[idx]; u = bank_u[idx]; cnt = bank_cnt[idx];
      hv = v; hu = u;
      for (int s = 0; s < 4; s++) begin
        kv[s] = clamp32(qmul(dt, rate_v(hv, hu, cur)));
        ku[s] = clamp32(qmul(dt, rate_u(hv, hu)));
        if (s < 2) begin
          hv = clamp32(v + (kv[s] >>> 1));
          hu = clamp32(u + (ku[s] >>> 1));
        end else begin
          hv = clamp32(v + kv[s]);
          hu = clamp32(u + ku[s]);
        end
      end
      v = rk4_sum(v, kv[0], kv[1], kv[2], kv[3]);
      u = rk4_sum(u, ku[0], ku[1], ku[2], ku[3]);
      if (v > reg_val(CFG_THRESHOLD)) begin
        v = reg_val(CFG_RESET_POT);
        u = clamp32(u + reg_val(CFG_REC_INC));
        if (cnt < 65535) cnt++;
        r.spk = 1;
      end
    end
    bank_v[idx] = v[31:0]; bank_u[idx] = u[31:0]; bank_cnt[idx] = cnt[15:0];
    r.pot = v[31:0]; r.rec = u[31:0]; r.total = cnt[15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    neuron_result_t want;
    if (!rst_n) begin
      coef_regs[CFG_COEF_A]    <= 24'd1311;
      coef_regs[CFG_COEF_B]    <= 24'd13107;
      coef_regs[CFG_RESET_POT] <= -24'sd4259840;
      coef_regs[CFG_REC_INC]   <= 24'd524288;
      coef_regs[CFG_TIME_STEP] <= 24'd6554;
      coef_regs[CFG_THRESHOLD] <= 24'd1966080;
      coef_regs[CFG_INIT_POT]  <= -24'sd4259840;
      coef_regs[CFG_INIT_REC]  <= -24'sd851968;
      fail_count <= 0;
    end else begin
      // coefficient write
      if (cfg_we) begin
        if (cfg_index == CFG_COEF_A || cfg_index == CFG_COEF_B ||
            cfg_index == CFG_TIME_STEP)
          coef_regs[cfg_index] <= {7'd0, cfg_wdata[16:0]};
        else
          coef_regs[cfg_index] <= cfg_wdata;
      end
      // accepted request
      if (in_req.valid && in_req.ready)
        result_queue.push_back(advance_neuron(in_req.req_type, in_req.neuron_index,
                                              in_req.drive_current));
      // accepted result
      if (out_res.valid && out_res.ready) begin
        if (result_queue.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result for neuron %0d", out_res.neuron_id);
          fail_count <= fail_count + 1;
        end else begin
          want = result_queue.pop_front();
          if (out_res.neuron_id !== want.id || out_res.potential !== want.pot ||
              out_res.recovery !== want.rec || out_res.spiked !== want.spk ||
              out_res.spike_total !== want.total) begin
            if (fail_count < 10)
              $display("mismatch id %0d/%0d v %0d/%0d u %0d/%0d spk %0b/%0b cnt %0d/%0d",
                       want.id, out_res.neuron_id, want.pot, out_res.potential,
                       want.rec, out_res.recovery, want.spk, out_res.spiked,
                       want.total, out_res.spike_total);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives step and init requests and coefficient writes into the neuron bank
// under several idling phases; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  import izh_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_wdata;
  int                  fail_count;
  int                  pending_results;
  int                  send_idle_pct;
  int                  sink_stall_pct;
  longint              cycle_count;
  bit                  ready_neuron[1024];
  int                  ready_list[$];

  izh_in_if  in_req ();
  izh_out_if out_res ();

  izhikevich_neuron_rk4_step dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  izh_rk4_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // timeout
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side stalls
  always @(posedge clk) begin
    if (!rst_n) out_res.ready <= 1'b0;
    else out_res.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // one request, with an optional random idle gap before it
  task automatic send_request(logic typ, logic [9:0] idx, logic signed [23:0] cur);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.req_type <= typ;
    in_req.neuron_index <= idx;
    in_req.drive_current <= cur;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    if (typ == REQ_INIT) begin
      if (!ready_neuron[idx]) ready_list.push_back(int'(idx));
      ready_neuron[idx] = 1'b1;
    end
  endtask

  task automatic wait_idle();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_coef(cfg_reg_t r, logic [23:0] val);
    cfg_we <= 1'b1; cfg_index <= r; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [23:0] pick_current();
    case ($urandom_range(3))
      0: return 24'(-$urandom_range(20 << 16) + $urandom_range(20 << 16));
      1: return 24'($urandom);
      2: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      default: return 24'($urandom_range(15 << 16));
    endcase
  endfunction

  // random traffic on a small active set, mostly steps
  task automatic random_burst(int count);
    int idx;
    for (int i = 0; i < count; i++) begin
      if (ready_list.size() == 0 || $urandom_range(9) == 0) begin
        idx = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(15);
        send_request(REQ_INIT, 10'(idx), 24'($urandom));
      end else begin
        idx = ready_list[$urandom_range(ready_list.size() - 1)];
        send_request(REQ_STEP, 10'(idx), pick_current());
      end
    end
  endtask

  initial begin
    in_req.valid = 0; in_req.req_type = REQ_STEP; in_req.neuron_index = 0;
    in_req.drive_current = 0; cfg_we = 0; cfg_index = CFG_COEF_A; cfg_wdata = 0;
    send_idle_pct = 0; sink_stall_pct = 0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes, both request kinds, back-to-back same neuron
    send_request(REQ_INIT, 10'd0, 24'sh7fffff);
    send_request(REQ_INIT, 10'd1023, 24'sh800000);
    send_request(REQ_STEP, 10'd0, 24'sh7fffff);
    send_request(REQ_STEP, 10'd1023, 24'sh800000);
    send_request(REQ_STEP, 10'd0, 24'sh000000);
    for (int i = 0; i < 12; i++) send_request(REQ_STEP, 10'd1023, 24'sd10 << 16);
    send_request(REQ_INIT, 10'd512, 24'sh555555);
    send_request(REQ_STEP, 10'd512, 24'shaaaaaa);
    send_request(REQ_STEP, 10'd512, 24'sh7fffff);
    wait_idle();

    // extreme coefficients, including the lowest threshold
    write_coef(CFG_COEF_A, 24'd65536);
    write_coef(CFG_COEF_B, 24'd65536);
    write_coef(CFG_RESET_POT, 24'sh800000);
    write_coef(CFG_REC_INC, 24'sh7fffff);
    write_coef(CFG_TIME_STEP, 24'd65536);
    write_coef(CFG_THRESHOLD, 24'sh800000);
    write_coef(CFG_INIT_POT, 24'sh7fffff);
    write_coef(CFG_INIT_REC, 24'sh800000);
    send_idle_pct = 0; sink_stall_pct = 0;
    random_burst(150);
    wait_idle();

    write_coef(CFG_COEF_A, 24'd0);
    write_coef(CFG_COEF_B, 24'd0);
    write_coef(CFG_TIME_STEP, 24'd0);
    write_coef(CFG_THRESHOLD, 24'sh7fffff);
    write_coef(CFG_RESET_POT, 24'sh7fffff);
    write_coef(CFG_REC_INC, 24'sh800000);
    write_coef(CFG_INIT_POT, 24'sh000000);
    write_coef(CFG_INIT_REC, 24'sh7fffff);
    send_idle_pct = 83;
    random_burst(150);
    wait_idle();

    // random coefficients around the usual operating point
    for (int ph = 0; ph < 4; ph++) begin
      write_coef(CFG_COEF_A, 24'($urandom_range(6553)));
      write_coef(CFG_COEF_B, 24'($urandom_range(19660)));
      write_coef(CFG_RESET_POT, 24'(-$urandom_range(70 << 16)));
      write_coef(CFG_REC_INC, 24'($urandom_range(10 << 16)));
      write_coef(CFG_TIME_STEP, 24'($urandom_range(65536)));
      write_coef(CFG_THRESHOLD, 24'($urandom_range(40 << 16)));
      write_coef(CFG_INIT_POT, 24'(-$urandom_range(70 << 16)));
      write_coef(CFG_INIT_REC, 24'(-$urandom_range(15 << 16)));
      case (ph)
        0: begin send_idle_pct = 0; sink_stall_pct = 0; end
        1: begin send_idle_pct = 0; sink_stall_pct = 83; end
        2: begin send_idle_pct = 10; sink_stall_pct = 10; end
        default: begin send_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      random_burst(400);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/izh_pkg.sv
hw/rtl/izh_in_if.sv
hw/rtl/izh_out_if.sv
hw/rtl/izh_ram.sv
hw/rtl/izh_rk_eval.sv
hw/rtl/izhikevich_neuron_rk4_step.sv
verif/izh_rk4_checker.sv
verif/tb.sv
